@@ hdl/itoa_pkg.sv @@
// Shared constants and helpers for the integer to radix ASCII converter.
`timescale 1ns / 1ps
`default_nettype none
package itoa_pkg;

    localparam int DIGIT_W  = 6;
    localparam int RADIX_W  = 6;
    localparam int CHAR_W   = 8;
    localparam int DIV_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_NINE) begin
            c = CH_LOWER_A + CHAR_W'(d - DIGIT_TEN);
        end else begin
            c = CH_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hdl/itoa_in_if.sv @@
// Input channel: value and radix with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface itoa_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                            valid;
    logic                            ready;
    logic signed [VALUE_WIDTH-1:0]   value;
    logic [itoa_pkg::RADIX_W-1:0]    base;

    modport source (output valid, output value, output base, input ready);
    modport sink   (input valid, input value, input base, output ready);
endinterface
`default_nettype wire

@@ hdl/itoa_out_if.sv @@
// Output channel: one ASCII character per item with a last flag.
`timescale 1ns / 1ps
`default_nettype none
interface itoa_out_if;
    logic                         valid;
    logic                         ready;
    logic [itoa_pkg::CHAR_W-1:0]  character;
    logic                         last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

@@ hdl/itoa_front.sv @@
// Front end: clamps the radix, detects negative decimal values, forms the magnitude.
`timescale 1ns / 1ps
`default_nettype none
module itoa_front #(
    parameter int VALUE_WIDTH = 32,
    localparam int JOB_W = VALUE_WIDTH + itoa_pkg::RADIX_W + 1
) (
    itoa_in_if.sink          i_in,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output logic [JOB_W-1:0] o_push_data
);

    logic [itoa_pkg::RADIX_W-1:0] radix;
    logic                         neg;
    logic [VALUE_WIDTH-1:0]       mag;

    always_comb begin
        if (i_in.base < itoa_pkg::RADIX_MIN) begin
            radix = itoa_pkg::RADIX_MIN;
        end else if (i_in.base > itoa_pkg::RADIX_MAX) begin
            radix = itoa_pkg::RADIX_MAX;
        end else begin
            radix = i_in.base;
        end
        neg = (radix == itoa_pkg::RADIX_DEC) && i_in.value[VALUE_WIDTH-1];
        if (neg) begin
            mag = VALUE_WIDTH'(~i_in.value + 1'b1);
        end else begin
            mag = i_in.value;
        end
    end

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;
    assign o_push_data  = {mag, radix, neg};

endmodule
`default_nettype wire

@@ hdl/itoa_queue.sv @@
// Two-entry job queue between the front end and the conversion engine.
`timescale 1ns / 1ps
`default_nettype none
module itoa_queue #(
    parameter int DATA_W = 39
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              n_wr_ptr;
    logic              n_rd_ptr;
    logic [1:0]        n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

@@ hdl/itoa_back.sv @@
// Conversion engine: radix division into a digit buffer, then reverse emission.
`timescale 1ns / 1ps
`default_nettype none
module itoa_back #(
    parameter int VALUE_WIDTH = 32,
    localparam int JOB_W = VALUE_WIDTH + itoa_pkg::RADIX_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  logic [JOB_W-1:0] i_job_data,
    itoa_out_if.source       o_out
);

    localparam int DIV_BITS = itoa_pkg::DIV_BITS;
    localparam int DIV_W    = ((VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int NSTEP    = DIV_W / DIV_BITS;
    localparam int STEP_W   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int IDX_W    = $clog2(VALUE_WIDTH);
    localparam int CNT_W    = $clog2(VALUE_WIDTH + 1);
    localparam int DIGIT_W  = itoa_pkg::DIGIT_W;
    localparam int RADIX_W  = itoa_pkg::RADIX_W;
    localparam int CHAR_W   = itoa_pkg::CHAR_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_PREP = 4'b0100,
        ST_EMIT = 4'b1000
    } t_back_state;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     n_quo;
    logic [DIGIT_W-1:0]   r_rem;
    logic [DIGIT_W-1:0]   n_rem;
    logic [RADIX_W-1:0]   r_radix;
    logic [RADIX_W-1:0]   n_radix;
    logic                 r_neg;
    logic                 n_neg;
    logic [STEP_W-1:0]    r_step;
    logic [STEP_W-1:0]    n_step;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [IDX_W-1:0]     n_rd_idx;
    logic [DIGIT_W-1:0]   r_rd_data;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic [CHAR_W-1:0]    n_out_char;
    logic                 r_out_last;
    logic                 n_out_last;
    logic [DIGIT_W-1:0]   r_buf [VALUE_WIDTH];

    logic [DIV_W-1:0]     div_quo;
    logic [DIGIT_W-1:0]   div_rem;
    logic                 wr_en;
    logic                 out_free;

    logic [VALUE_WIDTH-1:0] job_mag;
    logic [RADIX_W-1:0]     job_radix;
    logic                   job_neg;

    assign {job_mag, job_radix, job_neg} = i_job_data;

    // Long division by the radix, DIV_BITS dividend bits per cycle.
    always_comb begin : div_step
        logic [DIGIT_W-1:0]  rem;
        logic [DIGIT_W:0]    t;
        logic [DIV_BITS-1:0] qbits;
        rem   = r_rem;
        qbits = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {rem, r_quo[DIV_W-1-i]};
            if (t >= {1'b0, r_radix}) begin
                rem                     = DIGIT_W'(t - {1'b0, r_radix});
                qbits[DIV_BITS-1-i] = 1'b1;
            end else begin
                rem = t[DIGIT_W-1:0];
            end
        end
        div_rem = rem;
        div_quo = (r_quo << DIV_BITS) | DIV_W'(qbits);
    end

    assign out_free    = !r_out_valid || o_out.ready;
    assign o_job_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_neg       = r_neg;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_quo   = DIV_W'(job_mag);
                    n_radix = job_radix;
                    n_neg   = job_neg;
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_quo  = div_quo;
                n_rem  = div_rem;
                n_step = STEP_W'(r_step + 1'b1);
                if (r_step == STEP_W'(NSTEP - 1)) begin
                    wr_en  = 1'b1;
                    n_cnt  = CNT_W'(r_cnt + 1'b1);
                    n_rem  = '0;
                    n_step = '0;
                    if (div_quo == '0) begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                n_rd_idx = IDX_W'(r_cnt - CNT_W'(1));
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_out_char = itoa_pkg::CH_MINUS;
                        n_out_last = 1'b0;
                        n_neg      = 1'b0;
                    end else begin
                        n_out_char = itoa_pkg::digit_char(r_rd_data);
                        n_out_last = (r_rd_idx == '0);
                        if (r_rd_idx == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_rd_idx = IDX_W'(r_rd_idx - 1'b1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_neg       <= 1'b0;
            r_step      <= '0;
            r_cnt       <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_neg       <= n_neg;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_radix    <= n_radix;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_cnt[IDX_W-1:0]] <= div_rem;
        end
        r_rd_data <= r_buf[n_rd_idx];
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(VALUE_WIDTH))
        else $error("digit count beyond buffer depth");

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_radix))
        else $error("partial remainder not below radix");

    a_prep_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP) |-> (r_cnt != '0))
        else $error("emission started with no digits");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && !r_neg && r_rd_idx == '0)
        |=> (r_state == ST_IDLE && r_out_valid && r_out_last))
        else $error("final digit did not close the item");

endmodule
`default_nettype wire

@@ hdl/integer_to_radix_ascii.sv @@
// Top level of the integer to radix ASCII converter.
// Converts each input value to ASCII digits in radix 2..36 (base clamped into that range),
// most significant first, lower-case letters above nine, '-' prefix for negative values in
// radix ten only; other radices read the value as unsigned. One character leaves per output
// item, with last set on the final one. A two-entry queue decouples input from the engine.
// Per item the engine steps through idle, division, prep and emission states: the radix divider
// retires 8 dividend bits per cycle for each digit, then the digit buffer emits one char per
// cycle while the output is ready, with any '-' sent ahead of the digits.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_radix_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itoa_in_if.sink    i_in,
    itoa_out_if.source o_out
);

    localparam int JOB_W = VALUE_WIDTH + itoa_pkg::RADIX_W + 1;

    logic             push_valid;
    logic             push_ready;
    logic [JOB_W-1:0] push_data;
    logic             job_valid;
    logic             job_ready;
    logic [JOB_W-1:0] job_data;

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    itoa_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (job_valid),
        .i_pop_ready  (job_ready),
        .o_pop_data   (job_data)
    );

    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job_data  (job_data),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
